/* rtl/vdl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdl_pkg
// Shared types, constants and the microcode program of the vertex lighting
// block.
// ----------------------------------------------------------------------------
package vdl_pkg;

  localparam int MAX_LIGHTS = 6;
  localparam int LIDX_W     = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;

  localparam int COMP_W     = 16;
  localparam int LEVEL_W    = 16;
  localparam int COUNT_W    = 3;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int ACC_W      = 33;
  localparam int D14_W      = 18;
  localparam int MUL_A_W    = 19;
  localparam int MUL_B_W    = 17;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int FRAC_W     = 14;
  localparam int TERM_W     = PROD_W - FRAC_W;
  localparam int UC_AW      = 4;

  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMBIENT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_BASE  = 3'd2;

  localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(MAX_LIGHTS);

  typedef struct packed {
    logic        [15:0] intensity;
    logic signed [15:0] dir_z;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_x;
  } light_t;

  typedef enum logic [1:0] {MS_X, MS_Y, MS_Z, MS_INT} mul_sel_t;
  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_t;
  typedef enum logic [1:0] {JC_ALWAYS, JC_START, JC_MORE, JC_EMIT} jump_t;

  typedef struct packed {
    mul_sel_t         mul_sel;
    acc_op_t          acc_op;
    logic             sum_add;
    logic             advance;
    jump_t            jump;
    logic [UC_AW-1:0] tgt_a;
    logic [UC_AW-1:0] tgt_b;
  } ucode_t;

  typedef struct packed {
    ucode_t uc;
    logic   take;
    logic   emit;
  } vdl_ctl_t;

  typedef struct packed {
    logic more;
    logic no_lights;
    logic out_free;
  } vdl_stat_t;

  localparam logic [UC_AW-1:0] S_IDLE   = 4'd0;
  localparam logic [UC_AW-1:0] S_PRO_X  = 4'd1;
  localparam logic [UC_AW-1:0] S_PRO_Y  = 4'd2;
  localparam logic [UC_AW-1:0] S_PRO_Z  = 4'd3;
  localparam logic [UC_AW-1:0] S_LOOP_X = 4'd4;
  localparam logic [UC_AW-1:0] S_LOOP_I = 4'd5;
  localparam logic [UC_AW-1:0] S_LOOP_Y = 4'd6;
  localparam logic [UC_AW-1:0] S_LOOP_Z = 4'd7;
  localparam logic [UC_AW-1:0] S_EPI_A  = 4'd8;
  localparam logic [UC_AW-1:0] S_EPI_I  = 4'd9;
  localparam logic [UC_AW-1:0] S_EPI_S  = 4'd10;
  localparam logic [UC_AW-1:0] S_EMIT   = 4'd11;

  // acc_op and sum_add act on the product of the previous step.
  function automatic ucode_t ucode_rom(input logic [UC_AW-1:0] step);
    ucode_t w;
    begin
      w = '{MS_X, ACC_HOLD, 1'b0, 1'b0, JC_START, S_PRO_X, S_EMIT};
      unique case (step)
        S_IDLE:   w = '{MS_X,   ACC_HOLD, 1'b0, 1'b0, JC_START,  S_PRO_X,  S_EMIT};
        S_PRO_X:  w = '{MS_X,   ACC_HOLD, 1'b0, 1'b0, JC_ALWAYS, S_PRO_Y,  S_PRO_Y};
        S_PRO_Y:  w = '{MS_Y,   ACC_LOAD, 1'b0, 1'b0, JC_ALWAYS, S_PRO_Z,  S_PRO_Z};
        S_PRO_Z:  w = '{MS_Z,   ACC_ADD,  1'b0, 1'b1, JC_MORE,   S_LOOP_X, S_EPI_A};
        S_LOOP_X: w = '{MS_X,   ACC_ADD,  1'b0, 1'b0, JC_ALWAYS, S_LOOP_I, S_LOOP_I};
        S_LOOP_I: w = '{MS_INT, ACC_LOAD, 1'b0, 1'b0, JC_ALWAYS, S_LOOP_Y, S_LOOP_Y};
        S_LOOP_Y: w = '{MS_Y,   ACC_HOLD, 1'b1, 1'b0, JC_ALWAYS, S_LOOP_Z, S_LOOP_Z};
        S_LOOP_Z: w = '{MS_Z,   ACC_ADD,  1'b0, 1'b1, JC_MORE,   S_LOOP_X, S_EPI_A};
        S_EPI_A:  w = '{MS_X,   ACC_ADD,  1'b0, 1'b0, JC_ALWAYS, S_EPI_I,  S_EPI_I};
        S_EPI_I:  w = '{MS_INT, ACC_HOLD, 1'b0, 1'b0, JC_ALWAYS, S_EPI_S,  S_EPI_S};
        S_EPI_S:  w = '{MS_X,   ACC_HOLD, 1'b1, 1'b0, JC_ALWAYS, S_EMIT,   S_EMIT};
        S_EMIT:   w = '{MS_X,   ACC_HOLD, 1'b0, 1'b0, JC_EMIT,   S_IDLE,   S_EMIT};
        default:  w = '{MS_X,   ACC_HOLD, 1'b0, 1'b0, JC_ALWAYS, S_IDLE,   S_IDLE};
      endcase
      return w;
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/vdl_normal_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdl_normal_if
// Input channel: one vertex normal per transaction.
// ----------------------------------------------------------------------------
interface vdl_normal_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;

  modport source (output valid, output normal_x, output normal_y, output normal_z,
                  input ready);
  modport sink   (input valid, input normal_x, input normal_y, input normal_z,
                  output ready);
endinterface
`default_nettype wire

/* rtl/vdl_level_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdl_level_if
// Output channel: one light level per transaction.
// ----------------------------------------------------------------------------
interface vdl_level_if;
  logic        valid;
  logic        ready;
  logic [15:0] light_level;

  modport source (output valid, output light_level, input ready);
  modport sink   (input valid, input light_level, output ready);
endinterface
`default_nettype wire

/* rtl/vdl_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdl_cfg
// Configuration registers: light count, ambient level and the light words.
// ----------------------------------------------------------------------------
module vdl_cfg
  import vdl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic      [COUNT_W-1:0]    light_count,
  output logic      [LEVEL_W-1:0]    ambient_level,
  output light_t                     lights [MAX_LIGHTS]
);

  logic [CFG_IDX_W:0] slot;

  assign slot = {1'b0, cfg_index} - {1'b0, REG_LIGHT_BASE};

  always_ff @(posedge clk) begin
    if (rst) begin
      light_count   <= '0;
      ambient_level <= '0;
      for (int i = 0; i < MAX_LIGHTS; i++) begin
        lights[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_LIGHT_COUNT) begin
        light_count <= cfg_data[COUNT_W-1:0];
      end else if (cfg_index == REG_AMBIENT) begin
        ambient_level <= cfg_data[LEVEL_W-1:0];
      end else begin
        for (int i = 0; i < MAX_LIGHTS; i++) begin
          if (cfg_index >= REG_LIGHT_BASE && slot == (CFG_IDX_W+1)'(i)) begin
            lights[i] <= cfg_data;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/vdl_seq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdl_seq
// Microcode sequencer: step counter, program ROM and jump logic.
// ----------------------------------------------------------------------------
module vdl_seq
  import vdl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire vdl_stat_t stat,
  output logic           in_ready,
  output vdl_ctl_t       ctl
);

  logic [UC_AW-1:0] step;
  logic [UC_AW-1:0] step_next;
  ucode_t           uc;

  assign uc       = ucode_rom(step);
  assign in_ready = (uc.jump == JC_START);

  always_comb begin
    ctl.uc   = uc;
    ctl.take = (uc.jump == JC_START) && in_valid;
    ctl.emit = (uc.jump == JC_EMIT) && stat.out_free;
  end

  always_comb begin
    step_next = step;
    unique case (uc.jump)
      JC_ALWAYS: step_next = uc.tgt_a;
      JC_START: begin
        if (in_valid) begin
          step_next = stat.no_lights ? uc.tgt_b : uc.tgt_a;
        end
      end
      JC_MORE:   step_next = stat.more ? uc.tgt_a : uc.tgt_b;
      JC_EMIT: begin
        if (stat.out_free) begin
          step_next = uc.tgt_a;
        end
      end
      default:   step_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/vdl_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdl_datapath
// Shared multiplier, dot-product accumulator, level sum and output register.
// ----------------------------------------------------------------------------
module vdl_datapath
  import vdl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire vdl_ctl_t           ctl,
  input  wire logic signed [15:0] in_x,
  input  wire logic signed [15:0] in_y,
  input  wire logic signed [15:0] in_z,
  input  wire logic [COUNT_W-1:0] light_count,
  input  wire logic [LEVEL_W-1:0] ambient_level,
  input  wire light_t             lights [MAX_LIGHTS],
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic      [LEVEL_W-1:0] light_level,
  output vdl_stat_t               stat
);

  logic signed [COMP_W-1:0]  nx, ny, nz;
  logic        [LIDX_W-1:0]  light_idx;
  logic        [15:0]        int_prev;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic        [LEVEL_W-1:0] sum;

  logic        [COUNT_W-1:0] eff_count;
  logic                      more;
  light_t                    cur;
  logic        [D14_W-1:0]   d14;
  logic signed [MUL_A_W-1:0] op_a;
  logic signed [MUL_B_W-1:0] op_b;
  logic        [TERM_W-1:0]  term;
  logic        [TERM_W:0]    sum_wide;

  assign eff_count = (light_count > COUNT_LIMIT) ? COUNT_LIMIT : light_count;
  assign more      = ((COUNT_W+1)'(light_idx) + (COUNT_W+1)'(1)) < {1'b0, eff_count};
  assign cur       = lights[light_idx];

  // Negative or zero dot product contributes nothing.
  assign d14 = (!acc[ACC_W-1] && acc != '0) ? acc[FRAC_W+D14_W-1:FRAC_W] : '0;

  always_comb begin
    unique case (ctl.uc.mul_sel)
      MS_X: begin
        op_a = MUL_A_W'(nx);
        op_b = MUL_B_W'(cur.dir_x);
      end
      MS_Y: begin
        op_a = MUL_A_W'(ny);
        op_b = MUL_B_W'(cur.dir_y);
      end
      MS_Z: begin
        op_a = MUL_A_W'(nz);
        op_b = MUL_B_W'(cur.dir_z);
      end
      MS_INT: begin
        op_a = $signed({1'b0, d14});
        op_b = $signed({1'b0, int_prev});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign term     = prod[PROD_W-1:FRAC_W];
  assign sum_wide = {1'b0, term} + (TERM_W+1)'(sum);

  always_comb begin
    stat.more      = more;
    stat.no_lights = (eff_count == '0);
    stat.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;

    unique case (ctl.uc.acc_op)
      ACC_LOAD: acc <= prod[ACC_W-1:0];
      ACC_ADD:  acc <= acc + prod[ACC_W-1:0];
      default:  acc <= acc;
    endcase

    if (ctl.take) begin
      nx  <= in_x;
      ny  <= in_y;
      nz  <= in_z;
      sum <= '0;
    end else if (ctl.uc.sum_add) begin
      sum <= (sum_wide > (TERM_W+1)'({LEVEL_W{1'b1}})) ? '1 : sum_wide[LEVEL_W-1:0];
    end

    if (ctl.uc.advance) begin
      int_prev <= cur.intensity;
    end

    if (ctl.emit) begin
      light_level <= (sum < ambient_level) ? ambient_level : sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      light_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.take) begin
        light_idx <= '0;
      end else if (ctl.uc.advance && more) begin
        light_idx <= light_idx + LIDX_W'(1);
      end

      if (ctl.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/vertex_directional_lighting.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_directional_lighting
// Lambert diffuse lighting with an ambient floor for one vertex normal.
//
// normal: valid/ready channel, one signed Q1.14 normal per transaction.
// level:  valid/ready channel, one unsigned Q8.8 light level per transaction.
// cfg_we/cfg_index/cfg_data: register writes (0 light count, 1 ambient,
// 2..7 light words); write only while no transaction is in flight.
// A microcode sequencer runs one shared 19x17 multiplier every step: three
// direction products and one intensity product per light, the intensity
// product of one light overlapped into the steps that follow it.
// With N lights in use (N = 1..6) the prologue, one loop pass per further
// light and the epilogue run before the emit step; with no lights the idle
// step jumps to emit. A new normal is taken only in the idle step after emit.
// The result sits in an output register; a stalled receiver holds it and the
// sequencer waits in its final step until the register frees up.
// Reset clears the sequencer, output valid and all configuration registers.
// ----------------------------------------------------------------------------
module vertex_directional_lighting
  import vdl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  vdl_normal_if.sink                 normal,
  vdl_level_if.source                level
);

  logic [COUNT_W-1:0] light_count;
  logic [LEVEL_W-1:0] ambient_level;
  light_t             lights [MAX_LIGHTS];
  vdl_ctl_t           ctl;
  vdl_stat_t          stat;
  logic               in_ready;

  assign normal.ready = in_ready;

  vdl_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .light_count   (light_count),
    .ambient_level (ambient_level),
    .lights        (lights)
  );

  vdl_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (normal.valid),
    .stat     (stat),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  vdl_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .in_x          (normal.normal_x),
    .in_y          (normal.normal_y),
    .in_z          (normal.normal_z),
    .light_count   (light_count),
    .ambient_level (ambient_level),
    .lights        (lights),
    .out_ready     (level.ready),
    .out_valid     (level.valid),
    .light_level   (level.light_level),
    .stat          (stat)
  );

endmodule
`default_nettype wire

/* sim/vdl_level_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdl_level_checker
// Watches the configuration port and both channels of the vertex lighting
// block. Mirrors its registers, works out the light level of every accepted
// normal and compares each accepted level against the oldest pending one.
// ----------------------------------------------------------------------------
module vdl_level_checker
  import vdl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  normal_valid,
  input  logic                  normal_ready,
  input  logic signed [15:0]    normal_x,
  input  logic signed [15:0]    normal_y,
  input  logic signed [15:0]    normal_z,
  input  logic                  level_valid,
  input  logic                  level_ready,
  input  logic [LEVEL_W-1:0]    light_level,
  output int                    error_count,
  output int                    outstanding
);

  logic [COUNT_W-1:0] lamp_count;
  logic [LEVEL_W-1:0] ambient;
  light_t             lamps [MAX_LIGHTS];
  logic [LEVEL_W-1:0] expected_levels [$];

  function automatic logic [LEVEL_W-1:0] shade_vertex(input logic signed [15:0] nx,
                                                      input logic signed [15:0] ny,
                                                      input logic signed [15:0] nz);
    longint dot;
    longint acc;
    longint d14;
    int     n;
    light_t lt;
    acc = 0;
    n = (lamp_count > COUNT_LIMIT) ? MAX_LIGHTS : int'(lamp_count);
    for (int i = 0; i < n; i++) begin
      lt = lamps[i];
      dot = longint'(nx) * longint'($signed(lt.dir_x))
          + longint'(ny) * longint'($signed(lt.dir_y))
          + longint'(nz) * longint'($signed(lt.dir_z));
      if (dot > 0) begin
        d14 = dot >>> FRAC_W;
        acc = acc + ((d14 * longint'(lt.intensity)) >>> FRAC_W);
        if (acc > 65535) acc = 65535;
      end
    end
    if (acc < longint'(ambient)) acc = longint'(ambient);
    return acc[LEVEL_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic [LEVEL_W-1:0] want;
    if (rst) begin
      lamp_count = '0;
      ambient = '0;
      for (int i = 0; i < MAX_LIGHTS; i++) lamps[i] = '0;
      expected_levels.delete();
    end else begin
      if (level_valid && level_ready) begin
        if (expected_levels.size() == 0) begin
          if (error_count < 10)
            $display("%t: light_level %0d with no transaction pending", $time, light_level);
          error_count++;
        end else begin
          want = expected_levels.pop_front();
          if (want !== light_level) begin
            if (error_count < 10)
              $display("%t: light_level expected %0d got %0d", $time, want, light_level);
            error_count++;
          end
        end
      end
      if (normal_valid && normal_ready)
        expected_levels.push_back(shade_vertex(normal_x, normal_y, normal_z));
      if (cfg_we) begin
        case (cfg_index)
          REG_LIGHT_COUNT: lamp_count = cfg_data[COUNT_W-1:0];
          REG_AMBIENT:     ambient = cfg_data[LEVEL_W-1:0];
          default:         lamps[cfg_index - REG_LIGHT_BASE] = cfg_data;
        endcase
      end
    end
    outstanding = expected_levels.size();
  end

endmodule

/* sim/tb_vertex_directional_lighting.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vertex_directional_lighting
// Drives normals and register writes into the vertex lighting block under
// several light setups and idle/stall patterns; a checker module predicts and
// compares every light level. A watchdog ends a run that stops moving.
// ----------------------------------------------------------------------------
module tb_vertex_directional_lighting;
  import vdl_pkg::*;

  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 95;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int quiet_cycles       = 0;
  int errors;
  int outstanding;

  light_t lamp_set [MAX_LIGHTS];

  vdl_normal_if normal_ch ();
  vdl_level_if  level_ch ();

  vertex_directional_lighting u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .normal    (normal_ch),
    .level     (level_ch)
  );

  vdl_level_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .normal_valid (normal_ch.valid),
    .normal_ready (normal_ch.ready),
    .normal_x     (normal_ch.normal_x),
    .normal_y     (normal_ch.normal_y),
    .normal_z     (normal_ch.normal_z),
    .level_valid  (level_ch.valid),
    .level_ready  (level_ch.ready),
    .light_level  (level_ch.light_level),
    .error_count  (errors),
    .outstanding  (outstanding)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (receiver_stall_pct == 0) begin
      level_ch.ready <= 1'b1;
    end else begin
      level_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((normal_ch.valid && normal_ch.ready) || (level_ch.valid && level_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("vertex_directional_lighting test failed");
        $finish;
      end
    end
  end

  function automatic light_t make_lamp(input logic [15:0] x, input logic [15:0] y,
                                       input logic [15:0] z, input logic [15:0] gain);
    light_t l;
    l.dir_x = x;
    l.dir_y = y;
    l.dir_z = z;
    l.intensity = gain;
    return l;
  endfunction

  // mostly unit-range Q1.14 values, now and then any 16-bit pattern
  function automatic logic [15:0] random_component();
    int v;
    if ($urandom_range(3) == 0) return 16'($urandom);
    v = int'($urandom_range(32768)) - 16384;
    return 16'(v);
  endfunction

  function automatic logic [15:0] random_intensity();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($urandom_range(1024));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // upper bits of the narrow registers carry junk to check masking
  task automatic program_lighting(input logic [COUNT_W-1:0] count, input logic [15:0] amb);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(REG_LIGHT_COUNT, {junk[63:COUNT_W], count});
    write_reg(REG_AMBIENT, {junk[63:16], amb});
    for (int i = 0; i < MAX_LIGHTS; i++)
      write_reg(CFG_IDX_W'(REG_LIGHT_BASE + i), lamp_set[i]);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_normal(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      normal_ch.valid <= 1'b0;
      @(posedge clk);
    end
    normal_ch.valid    <= 1'b1;
    normal_ch.normal_x <= x;
    normal_ch.normal_y <= y;
    normal_ch.normal_z <= z;
    @(posedge clk);
    while (!normal_ch.ready) @(posedge clk);
  endtask

  initial begin
    logic [COUNT_W-1:0] count;
    logic [15:0]        amb;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    normal_ch.valid = 1'b0;
    normal_ch.normal_x = '0;
    normal_ch.normal_y = '0;
    normal_ch.normal_z = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // count of 7 clamps to six lights; extreme directions and gains
    lamp_set[0] = make_lamp(16'd16384, 16'd0, 16'd0, 16'h0100);
    lamp_set[1] = make_lamp(16'd0, 16'd16384, 16'd0, 16'h0200);
    lamp_set[2] = make_lamp(16'd0, 16'd0, 16'd16384, 16'hFFFF);
    lamp_set[3] = make_lamp(16'h8000, 16'h8000, 16'h8000, 16'hFFFF);
    lamp_set[4] = make_lamp(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0080);
    lamp_set[5] = make_lamp(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    program_lighting(3'd7, 16'h0040);
    send_normal(16'd0, 16'd0, 16'd0);
    send_normal(16'd16384, 16'd0, 16'd0);
    send_normal(16'd0, 16'd16384, 16'd0);
    send_normal(16'd0, 16'd0, 16'd16384);
    send_normal(-16'sd16384, 16'd0, 16'd0);
    send_normal(16'h8000, 16'h8000, 16'h8000);
    send_normal(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_normal(16'h7FFF, 16'h8000, 16'd0);
    send_normal(16'd1, 16'd1, 16'd1);
    send_normal(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_normal(16'd0, -16'sd16384, 16'd0);
    normal_ch.valid <= 1'b0;
    drain();

    // single light: plain term, negative dot clamped, truncation to zero
    lamp_set[0] = make_lamp(16'd16384, 16'd0, 16'd0, 16'h0100);
    program_lighting(3'd1, 16'h0000);
    send_normal(16'd16384, 16'd0, 16'd0);
    send_normal(-16'sd16384, 16'd0, 16'd0);
    send_normal(16'd8192, 16'd0, 16'd0);
    send_normal(16'd1, 16'd0, 16'd0);
    normal_ch.valid <= 1'b0;
    drain();

    // no lights: level is the ambient floor
    program_lighting(3'd0, 16'hFFFF);
    send_normal(16'd0, 16'd0, 16'd0);
    send_normal(16'd16384, 16'd16384, 16'd16384);
    normal_ch.valid <= 1'b0;
    drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      for (int i = 0; i < MAX_LIGHTS; i++)
        lamp_set[i] = make_lamp(random_component(), random_component(), random_component(),
                                random_intensity());
      case (phase)
        0:       count = 3'd6;
        1:       count = 3'd7;
        2:       count = 3'd0;
        default: count = 3'($urandom_range(7));
      endcase
      case (phase)
        0:       amb = 16'h0000;
        3:       amb = 16'hFFFF;
        default: amb = ($urandom_range(2) == 0) ? 16'($urandom) : 16'($urandom_range(2048));
      endcase
      program_lighting(count, amb);
      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 85; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 85; end
        default: begin sender_idle_pct = 17; receiver_stall_pct = 17; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_normal(random_component(), random_component(), random_component());
      normal_ch.valid <= 1'b0;
      drain();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("vertex_directional_lighting test passed");
    end else begin
      $display("vertex_directional_lighting test failed");
    end
    $finish;
  end

endmodule
